// File: rtl/ppm_pkg.sv
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared types and constants of the PPM level meter: field widths, register
// indexes, dB constants in signed Q8.8, and the controller command and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppm_pkg;

  // field widths
  localparam int ELAPSED_W  = 16;
  localparam int PEAK_W     = 16;
  localparam int SQ_W       = 43;
  localparam int FRAMES_W   = 13;
  localparam int LEVEL_W    = 15;
  localparam int SEG_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LOG_W      = 22;
  localparam int DB_W       = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TICK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RMS_CAL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CREST_FLOOR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_MAX   = 3'd6;

  // dB limits, Q8.8
  localparam logic signed [DB_W-1:0] DB_OFF         = -16'sd15360;
  localparam logic signed [DB_W-1:0] DB_TARGET_MAX  = 16'sd1280;
  localparam logic signed [DB_W-1:0] DB_MEASURE_MIN = -16'sd30720;
  localparam logic signed [DB_W-1:0] ACT_DOWN       = -16'sd512;
  localparam logic signed [DB_W-1:0] ACT_UP         = 16'sd256;

  // 20*log10(2) in Q16
  localparam logic signed [19:0] K_20LOG2 = 20'sd394566;
  // log2 offsets in Q16: full scale peak and full scale square
  localparam logic signed [23:0] LOG_OFS_PEAK = 24'sd983040;
  localparam logic signed [23:0] LOG_OFS_RMS  = 24'sd1966080;

  // reciprocal of 1000 scaled by 2^36, rounded down
  localparam logic [26:0] RECIP_1000 = 27'd68719476;
  localparam int          RECIP_SH   = 36;

  // segment thresholds, ascending
  localparam logic signed [DB_W-1:0] SEG_THR [16] = '{
    -16'sd5120, -16'sd2048, -16'sd768, -16'sd256, 16'sd0, 16'sd256, 16'sd512, 16'sd1280,
    16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
    16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767
  };

  typedef enum logic [2:0] {
    OP_SLOW_N,
    OP_FAST_N,
    OP_PEAK,
    OP_SLOW_SQ,
    OP_FAST_SQ
  } log_op_t;

  typedef enum logic [1:0] {
    SEL_PEAK,
    SEL_SLOW,
    SEL_FAST
  } db_sel_t;

  typedef struct packed {
    logic    load;
    logic    log_start;
    log_op_t log_op;
    logic    db_mul;
    logic    db_rnd;
    db_sel_t db_sel;
    logic    comb;
    logic    tgt;
    logic    ball;
    logic    out_load;
    logic    ch;
  } cmd_t;

  typedef struct packed {
    logic log_done;
    logic new_block;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/ppm_log2.sv
// ----------------------------------------------------------------------------
// ppm_log2
// Iterative log2 in Q.16: normalise the operand a byte or a bit per cycle,
// then one squaring of the Q1.30 mantissa per fraction bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppm_log2 (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [ppm_pkg::SQ_W-1:0]   x,
  output logic                            done,
  output logic [ppm_pkg::LOG_W-1:0]       result
);

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ} lstate_t;

  lstate_t                    state;
  logic [ppm_pkg::SQ_W-1:0]   xr;
  logic [5:0]                 e;
  logic [30:0]                m;
  logic [15:0]                frac;
  logic [3:0]                 cnt;
  logic [61:0]                sq;
  logic [31:0]                sq_sh;
  logic                       fbit;
  logic [30:0]                m_next;

  // mantissa squaring step
  always_comb begin
    sq     = {31'd0, m} * {31'd0, m};
    sq_sh  = sq[61:30];
    fbit   = sq_sh[31];
    m_next = fbit ? sq_sh[31:1] : sq_sh[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (start) begin
            if (x == '0) begin
              result <= '0;
              done   <= 1'b1;
            end else begin
              xr    <= x;
              e     <= 6'd42;
              state <= L_NORM;
            end
          end
        end
        // left-align the leading one
        L_NORM: begin
          if (xr[42]) begin
            m     <= xr[42:12];
            frac  <= '0;
            cnt   <= '0;
            state <= L_SQ;
          end else if (xr[42:35] == 8'd0) begin
            xr <= {xr[34:0], 8'd0};
            e  <= e - 6'd8;
          end else begin
            xr <= {xr[41:0], 1'b0};
            e  <= e - 6'd1;
          end
        end
        // one fraction bit per cycle
        L_SQ: begin
          m    <= m_next;
          frac <= {frac[14:0], fbit};
          cnt  <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            result <= {e, frac[14:0], fbit};
            done   <= 1'b1;
            state  <= L_IDLE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/ppm_datapath.sv
// ----------------------------------------------------------------------------
// ppm_datapath
// Registers, log unit, dB scaling, target forming and ballistics of the
// meter; steered step by step by the controller commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppm_datapath #(
  parameter int MAX_FRAMES = 4096,
  parameter int SEGMENTS   = 8,
  parameter int CHANNELS   = 2
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire ppm_pkg::cmd_t                      cmd,
  output ppm_pkg::status_t                        status,
  input  wire logic [ppm_pkg::ELAPSED_W-1:0]      elapsed_ms,
  input  wire logic                               restart,
  input  wire logic                               new_block,
  input  wire logic [ppm_pkg::PEAK_W-1:0]         peak_left,
  input  wire logic [ppm_pkg::PEAK_W-1:0]         peak_right,
  input  wire logic [ppm_pkg::SQ_W-1:0]           slow_sq_left,
  input  wire logic [ppm_pkg::SQ_W-1:0]           slow_sq_right,
  input  wire logic [ppm_pkg::FRAMES_W-1:0]       slow_frames,
  input  wire logic [ppm_pkg::SQ_W-1:0]           fast_sq_left,
  input  wire logic [ppm_pkg::SQ_W-1:0]           fast_sq_right,
  input  wire logic [ppm_pkg::FRAMES_W-1:0]       fast_frames,
  input  wire logic                               cfg_write,
  input  wire logic [ppm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ppm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic signed [ppm_pkg::LEVEL_W-1:0]      level_left,
  output logic signed [ppm_pkg::LEVEL_W-1:0]      level_right,
  output logic [ppm_pkg::SEG_W-1:0]               segments_left,
  output logic [ppm_pkg::SEG_W-1:0]               segments_right
);

  localparam logic [31:0] MAX_F = 32'(MAX_FRAMES);

  // configuration
  logic [9:0]  hold_time;
  logic [7:0]  release_rate;
  logic [9:0]  max_tick;
  logic [15:0] stale;
  logic [5:0]  rms_cal;
  logic [5:0]  crest_floor;
  logic [3:0]  boost_max;

  // meter state
  logic signed [ppm_pkg::DB_W-1:0] target  [2];
  logic signed [ppm_pkg::DB_W-1:0] disp    [2];
  logic [9:0]                      hold    [2];
  logic [15:0]                     tsb;
  logic                            seen;

  // captured request
  logic                            new_block_r;
  logic [9:0]                      dt;
  logic [ppm_pkg::PEAK_W-1:0]      peak_r  [2];
  logic [ppm_pkg::SQ_W-1:0]        ssq_r   [2];
  logic [ppm_pkg::SQ_W-1:0]        fsq_r   [2];
  logic [ppm_pkg::FRAMES_W-1:0]    sn_r;
  logic [ppm_pkg::FRAMES_W-1:0]    fn_r;
  logic [ppm_pkg::FRAMES_W-1:0]    sn_sat;
  logic [ppm_pkg::FRAMES_W-1:0]    fn_sat;
  logic [16:0]                     tsb_sum;
  logic [15:0]                     tsb_base;

  // log results
  logic [ppm_pkg::LOG_W-1:0]       lg_sn;
  logic [ppm_pkg::LOG_W-1:0]       lg_fn;
  logic [ppm_pkg::LOG_W-1:0]       lg_pk   [2];
  logic [ppm_pkg::LOG_W-1:0]       lg_ss   [2];
  logic [ppm_pkg::LOG_W-1:0]       lg_fs   [2];
  logic [ppm_pkg::SQ_W-1:0]        log_x;
  logic                            log_done;
  logic [ppm_pkg::LOG_W-1:0]       log_res;

  // dB scaling
  logic signed [23:0]              db_d;
  logic signed [43:0]              db_prod;
  logic                            db_neg;
  logic [43:0]                     db_mag;
  logic [43:0]                     db_rsum;
  logic [19:0]                     db_r;
  logic signed [ppm_pkg::DB_W-1:0] db_val;
  logic                            db_zero;
  logic signed [ppm_pkg::DB_W-1:0] db_pk;
  logic signed [ppm_pkg::DB_W-1:0] db_slow;
  logic signed [ppm_pkg::DB_W-1:0] db_fast;

  // target forming
  logic                            pk_zero;
  logic                            ssq_zero;
  logic                            fsq_zero;
  logic                            sn_zero;
  logic                            fn_zero;
  logic signed [18:0]              act_x3;
  logic [18:0]                     act_mag;
  logic [18:0]                     act_half;
  logic signed [18:0]              act_v;
  logic signed [17:0]              boost_v;
  logic signed [ppm_pkg::DB_W-1:0] act_r;
  logic signed [ppm_pkg::DB_W-1:0] boost_r;
  logic signed [17:0]              tgt_sum;
  logic signed [ppm_pkg::DB_W-1:0] tgt_val;

  // release step
  logic [25:0]                     rel_n;
  logic [52:0]                     rel_p;
  logic [16:0]                     rel_q0;
  logic [26:0]                     rel_rem;
  logic [16:0]                     step;

  // ballistics
  logic                            silent;
  logic signed [ppm_pkg::DB_W-1:0] tgt_eff   [2];
  logic signed [ppm_pkg::DB_W-1:0] disp_next [2];
  logic [9:0]                      hold_next [2];
  logic signed [17:0]              rel_d     [2];

  function automatic logic [ppm_pkg::SEG_W-1:0] seg_count(
    input logic signed [ppm_pkg::DB_W-1:0] db
  );
    logic [ppm_pkg::SEG_W-1:0] n;
    n = '0;
    for (int i = 0; i < 16; i++) begin
      if (i < SEGMENTS && db >= ppm_pkg::SEG_THR[i]) n = ppm_pkg::SEG_W'(i + 1);
    end
    return n;
  endfunction

  assign status.log_done  = log_done;
  assign status.new_block = new_block_r;

  // frame count saturation and block age
  always_comb begin
    sn_sat   = ({19'd0, slow_frames} > MAX_F) ? ppm_pkg::FRAMES_W'(MAX_FRAMES) : slow_frames;
    fn_sat   = ({19'd0, fast_frames} > MAX_F) ? ppm_pkg::FRAMES_W'(MAX_FRAMES) : fast_frames;
    tsb_base = restart ? 16'd0 : tsb;
    tsb_sum  = {1'b0, tsb_base} + {1'b0, elapsed_ms};
  end

  // zero flags of the current channel
  always_comb begin
    pk_zero  = (peak_r[cmd.ch] == '0);
    ssq_zero = (ssq_r[cmd.ch] == '0);
    fsq_zero = (fsq_r[cmd.ch] == '0);
    sn_zero  = (sn_r == '0);
    fn_zero  = (fn_r == '0);
  end

  // log operand select
  always_comb begin
    unique case (cmd.log_op)
      ppm_pkg::OP_SLOW_N:  log_x = {30'd0, sn_r};
      ppm_pkg::OP_FAST_N:  log_x = {30'd0, fn_r};
      ppm_pkg::OP_PEAK:    log_x = {27'd0, peak_r[cmd.ch]};
      ppm_pkg::OP_SLOW_SQ: log_x = ssq_r[cmd.ch];
      ppm_pkg::OP_FAST_SQ: log_x = fsq_r[cmd.ch];
      default:             log_x = '0;
    endcase
  end

  ppm_log2 u_log2 (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.log_start),
    .x      (log_x),
    .done   (log_done),
    .result (log_res)
  );

  // log difference to be scaled to dB
  always_comb begin
    unique case (cmd.db_sel)
      ppm_pkg::SEL_PEAK:
        db_d = $signed({2'b00, lg_pk[cmd.ch]}) - ppm_pkg::LOG_OFS_PEAK;
      ppm_pkg::SEL_SLOW:
        db_d = $signed({2'b00, lg_ss[cmd.ch]}) - $signed({2'b00, lg_sn})
               - ppm_pkg::LOG_OFS_RMS;
      ppm_pkg::SEL_FAST:
        db_d = $signed({2'b00, lg_fs[cmd.ch]}) - $signed({2'b00, lg_fn})
               - ppm_pkg::LOG_OFS_RMS;
      default: db_d = '0;
    endcase
  end

  // round half away from zero, clamp to -120..0 dB
  always_comb begin
    db_neg  = db_prod[43];
    db_mag  = db_neg ? 44'(-db_prod) : 44'(db_prod);
    if (cmd.db_sel == ppm_pkg::SEL_PEAK) begin
      db_rsum = db_mag + (44'd1 << 23);
      db_r    = db_rsum[43:24];
    end else begin
      db_rsum = db_mag + (44'd1 << 24);
      db_r    = {1'b0, db_rsum[43:25]};
    end
    if (!db_neg) db_val = '0;
    else if (db_r > 20'd30720) db_val = ppm_pkg::DB_MEASURE_MIN;
    else db_val = -$signed({1'b0, db_r[14:0]});
    unique case (cmd.db_sel)
      ppm_pkg::SEL_PEAK: db_zero = pk_zero;
      ppm_pkg::SEL_SLOW: db_zero = ssq_zero || sn_zero;
      ppm_pkg::SEL_FAST: db_zero = fsq_zero || fn_zero;
      default:           db_zero = 1'b1;
    endcase
  end

  // activity and crest boost
  always_comb begin
    act_x3   = 19'sd3 * ($signed({{3{db_fast[15]}}, db_fast})
                         - $signed({{3{db_slow[15]}}, db_slow}));
    act_mag  = act_x3[18] ? 19'(-act_x3) : 19'(act_x3);
    act_half = (act_mag + 19'd1) >> 1;
    act_v    = act_x3[18] ? -$signed(act_half) : $signed(act_half);
    boost_v  = $signed({{2{db_pk[15]}}, db_pk}) - $signed({{2{db_slow[15]}}, db_slow})
               - $signed({4'd0, crest_floor, 8'd0});
  end

  // target sum and clamp
  always_comb begin
    tgt_sum = $signed({{2{db_slow[15]}}, db_slow}) + $signed({4'd0, rms_cal, 8'd0})
              + $signed({{2{act_r[15]}}, act_r}) + $signed({{2{boost_r[15]}}, boost_r});
    if (sn_zero) tgt_val = ppm_pkg::DB_OFF;
    else if (tgt_sum < 18'(ppm_pkg::DB_OFF)) tgt_val = ppm_pkg::DB_OFF;
    else if (tgt_sum > 18'(ppm_pkg::DB_TARGET_MAX)) tgt_val = ppm_pkg::DB_TARGET_MAX;
    else tgt_val = tgt_sum[15:0];
  end

  // release step correction after the reciprocal product
  always_comb begin
    rel_q0  = rel_p[52:ppm_pkg::RECIP_SH];
    rel_rem = {1'b0, rel_n} - 27'({10'd0, rel_q0} * 27'd1000);
  end

  // ballistics next values
  always_comb begin
    silent = !seen || (tsb > stale);
    for (int c = 0; c < 2; c++) begin
      tgt_eff[c]   = silent ? ppm_pkg::DB_OFF : target[c];
      rel_d[c]     = $signed({{2{disp[c][15]}}, disp[c]}) - $signed({1'b0, step});
      disp_next[c] = disp[c];
      hold_next[c] = hold[c];
      if (tgt_eff[c] >= disp[c]) begin
        disp_next[c] = tgt_eff[c];
        hold_next[c] = hold_time;
      end else if (hold[c] != 10'd0) begin
        hold_next[c] = (hold[c] > dt) ? hold[c] - dt : 10'd0;
      end else if (rel_d[c] < 18'(tgt_eff[c])) begin
        disp_next[c] = tgt_eff[c];
      end else if (rel_d[c] < 18'(ppm_pkg::DB_OFF)) begin
        disp_next[c] = ppm_pkg::DB_OFF;
      end else begin
        disp_next[c] = rel_d[c][15:0];
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time    <= 10'd120;
      release_rate <= 8'd12;
      max_tick     <= 10'd100;
      stale        <= 16'd300;
      rms_cal      <= 6'd14;
      crest_floor  <= 6'd10;
      boost_max    <= 4'd4;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ppm_pkg::CFG_HOLD_TIME:   hold_time    <= cfg_data[9:0];
        ppm_pkg::CFG_RELEASE:     release_rate <= cfg_data[7:0];
        ppm_pkg::CFG_MAX_TICK:    max_tick     <= cfg_data[9:0];
        ppm_pkg::CFG_STALE:       stale        <= cfg_data;
        ppm_pkg::CFG_RMS_CAL:     rms_cal      <= cfg_data[5:0];
        ppm_pkg::CFG_CREST_FLOOR: crest_floor  <= cfg_data[5:0];
        ppm_pkg::CFG_BOOST_MAX:   boost_max    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // meter state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 2; c++) begin
        target[c] <= ppm_pkg::DB_OFF;
        disp[c]   <= ppm_pkg::DB_OFF;
        hold[c]   <= 10'd0;
      end
      tsb  <= 16'd0;
      seen <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (restart) begin
          for (int c = 0; c < 2; c++) begin
            target[c] <= ppm_pkg::DB_OFF;
            disp[c]   <= ppm_pkg::DB_OFF;
            hold[c]   <= 10'd0;
          end
        end
        if (new_block) begin
          seen <= 1'b1;
          tsb  <= 16'd0;
        end else begin
          seen <= seen && !restart;
          tsb  <= tsb_sum[16] ? 16'hFFFF : tsb_sum[15:0];
        end
      end
      if (cmd.tgt) target[cmd.ch] <= tgt_val;
      if (cmd.ball) begin
        for (int c = 0; c < 2; c++) begin
          disp[c] <= disp_next[c];
          hold[c] <= hold_next[c];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      new_block_r <= new_block;
      dt          <= (elapsed_ms > {6'd0, max_tick}) ? max_tick : elapsed_ms[9:0];
      peak_r[0]   <= peak_left;
      peak_r[1]   <= peak_right;
      ssq_r[0]    <= slow_sq_left;
      ssq_r[1]    <= slow_sq_right;
      fsq_r[0]    <= fast_sq_left;
      fsq_r[1]    <= fast_sq_right;
      sn_r        <= sn_sat;
      fn_r        <= fn_sat;
    end
    // release step pipeline: dt, then rel_n, rel_p and step
    rel_n <= {18'({8'd0, release_rate} * {8'd0, dt}), 8'd0} + 26'd500;
    rel_p <= {27'd0, rel_n} * {26'd0, ppm_pkg::RECIP_1000};
    step  <= (rel_rem >= 27'd1000) ? rel_q0 + 17'd1 : rel_q0;
    if (log_done) begin
      unique case (cmd.log_op)
        ppm_pkg::OP_SLOW_N:  lg_sn          <= log_res;
        ppm_pkg::OP_FAST_N:  lg_fn          <= log_res;
        ppm_pkg::OP_PEAK:    lg_pk[cmd.ch]  <= log_res;
        ppm_pkg::OP_SLOW_SQ: lg_ss[cmd.ch]  <= log_res;
        ppm_pkg::OP_FAST_SQ: lg_fs[cmd.ch]  <= log_res;
        default: ;
      endcase
    end
    if (cmd.db_mul) db_prod <= db_d * ppm_pkg::K_20LOG2;
    if (cmd.db_rnd) begin
      unique case (cmd.db_sel)
        ppm_pkg::SEL_PEAK: db_pk   <= db_zero ? ppm_pkg::DB_MEASURE_MIN : db_val;
        ppm_pkg::SEL_SLOW: db_slow <= db_zero ? ppm_pkg::DB_MEASURE_MIN : db_val;
        ppm_pkg::SEL_FAST: db_fast <= db_zero ? ppm_pkg::DB_MEASURE_MIN : db_val;
        default: ;
      endcase
    end
    if (cmd.comb) begin
      if (ssq_zero || fsq_zero || fn_zero) act_r <= '0;
      else if (act_v < 19'(ppm_pkg::ACT_DOWN)) act_r <= ppm_pkg::ACT_DOWN;
      else if (act_v > 19'(ppm_pkg::ACT_UP)) act_r <= ppm_pkg::ACT_UP;
      else act_r <= act_v[15:0];
      if (boost_v < 18'sd0) boost_r <= '0;
      else if (boost_v > $signed({6'd0, boost_max, 8'd0})) boost_r <= {4'd0, boost_max, 8'd0};
      else boost_r <= boost_v[15:0];
    end
    if (cmd.out_load) begin
      level_left     <= disp[0][ppm_pkg::LEVEL_W-1:0];
      segments_left  <= seg_count(disp[0]);
      if (CHANNELS >= 2) begin
        level_right    <= disp[1][ppm_pkg::LEVEL_W-1:0];
        segments_right <= seg_count(disp[1]);
      end else begin
        level_right    <= ppm_pkg::DB_OFF[ppm_pkg::LEVEL_W-1:0];
        segments_right <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/ppm_ctrl.sv
// ----------------------------------------------------------------------------
// ppm_ctrl
// Sequencer of the meter: takes a request; for a new block runs the log
// operations, dB scaling, target forming per channel; then ballistics, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ppm_pkg::cmd_t          cmd,
  input  wire ppm_pkg::status_t  status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_LOG_GO,
    S_LOG_WAIT,
    S_DB_MUL,
    S_DB_RND,
    S_COMB,
    S_TGT,
    S_BALL,
    S_OUT
  } state_t;

  state_t            state;
  logic [1:0]        prep_cnt;
  ppm_pkg::log_op_t  op;
  ppm_pkg::db_sel_t  sel;
  logic              ch;

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.log_op    = op;
    cmd.db_sel    = sel;
    cmd.ch        = ch;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.log_start = (state == S_LOG_GO);
    cmd.db_mul    = (state == S_DB_MUL);
    cmd.db_rnd    = (state == S_DB_RND);
    cmd.comb      = (state == S_COMB);
    cmd.tgt       = (state == S_TGT);
    cmd.ball      = (state == S_BALL);
    cmd.out_load  = (state == S_OUT) && (!out_valid || !out_stall);
    in_stall      = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      prep_cnt  <= '0;
      op        <= ppm_pkg::OP_SLOW_N;
      sel       <= ppm_pkg::SEL_PEAK;
      ch        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // result register handshake
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            prep_cnt <= '0;
            state    <= S_PREP;
          end
        end
        // release step settles meanwhile
        S_PREP: begin
          prep_cnt <= prep_cnt + 2'd1;
          if (prep_cnt == 2'd2) begin
            if (status.new_block) begin
              op    <= ppm_pkg::OP_SLOW_N;
              ch    <= 1'b0;
              state <= S_LOG_GO;
            end else begin
              state <= S_BALL;
            end
          end
        end
        S_LOG_GO: state <= S_LOG_WAIT;
        S_LOG_WAIT: begin
          if (status.log_done) begin
            unique case (op)
              ppm_pkg::OP_SLOW_N: begin
                op    <= ppm_pkg::OP_FAST_N;
                state <= S_LOG_GO;
              end
              ppm_pkg::OP_FAST_N: begin
                op    <= ppm_pkg::OP_PEAK;
                ch    <= 1'b0;
                state <= S_LOG_GO;
              end
              ppm_pkg::OP_PEAK: begin
                op    <= ppm_pkg::OP_SLOW_SQ;
                state <= S_LOG_GO;
              end
              ppm_pkg::OP_SLOW_SQ: begin
                op    <= ppm_pkg::OP_FAST_SQ;
                state <= S_LOG_GO;
              end
              ppm_pkg::OP_FAST_SQ: begin
                if (!ch) begin
                  ch    <= 1'b1;
                  op    <= ppm_pkg::OP_PEAK;
                  state <= S_LOG_GO;
                end else begin
                  ch    <= 1'b0;
                  sel   <= ppm_pkg::SEL_PEAK;
                  state <= S_DB_MUL;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_DB_MUL: state <= S_DB_RND;
        S_DB_RND: begin
          unique case (sel)
            ppm_pkg::SEL_PEAK: begin
              sel   <= ppm_pkg::SEL_SLOW;
              state <= S_DB_MUL;
            end
            ppm_pkg::SEL_SLOW: begin
              sel   <= ppm_pkg::SEL_FAST;
              state <= S_DB_MUL;
            end
            default: state <= S_COMB;
          endcase
        end
        S_COMB: state <= S_TGT;
        S_TGT: begin
          if (!ch) begin
            ch    <= 1'b1;
            sel   <= ppm_pkg::SEL_PEAK;
            state <= S_DB_MUL;
          end else begin
            state <= S_BALL;
          end
        end
        S_BALL: state <= S_OUT;
        S_OUT: begin
          if (cmd.out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/audio_ppm_level_meter_core.sv
// ----------------------------------------------------------------------------
// audio_ppm_level_meter_core
// Stereo peak programme meter: per tick, optional new statistics block gives
// per-channel dB targets; displayed levels follow with attack, hold, release.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | elapsed_ms, restart, new_block, peaks, sums, frames
//  out     | out_valid / out_stall| level_left/right (Q7.8), segments_left/right
//  cfg     | cfg_write            | cfg_index, cfg_data
//
//  a tick without a block skips the log2 unit; a tick with a block makes
//  eight passes through the one shared log2 unit (each a normalise phase,
//  the squaring steps and a start and hand-over)
//  one request at a time; the next request is taken while the result waits,
//  and its result is held back until the waiting one is taken
//  synchronous active-high reset restores register defaults and a silent meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module audio_ppm_level_meter_core #(
  parameter int MAX_FRAMES = 4096,
  parameter int SEGMENTS   = 8,
  parameter int CHANNELS   = 2
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [ppm_pkg::ELAPSED_W-1:0]      elapsed_ms,
  input  wire logic                               restart,
  input  wire logic                               new_block,
  input  wire logic [ppm_pkg::PEAK_W-1:0]         peak_left,
  input  wire logic [ppm_pkg::PEAK_W-1:0]         peak_right,
  input  wire logic [ppm_pkg::SQ_W-1:0]           slow_sq_left,
  input  wire logic [ppm_pkg::SQ_W-1:0]           slow_sq_right,
  input  wire logic [ppm_pkg::FRAMES_W-1:0]       slow_frames,
  input  wire logic [ppm_pkg::SQ_W-1:0]           fast_sq_left,
  input  wire logic [ppm_pkg::SQ_W-1:0]           fast_sq_right,
  input  wire logic [ppm_pkg::FRAMES_W-1:0]       fast_frames,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [ppm_pkg::LEVEL_W-1:0]      level_left,
  output logic signed [ppm_pkg::LEVEL_W-1:0]      level_right,
  output logic [ppm_pkg::SEG_W-1:0]               segments_left,
  output logic [ppm_pkg::SEG_W-1:0]               segments_right,
  input  wire logic                               cfg_write,
  input  wire logic [ppm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ppm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  ppm_pkg::cmd_t    cmd;
  ppm_pkg::status_t status;

  // sequencer
  ppm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // arithmetic and state
  ppm_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .SEGMENTS   (SEGMENTS),
    .CHANNELS   (CHANNELS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .elapsed_ms     (elapsed_ms),
    .restart        (restart),
    .new_block      (new_block),
    .peak_left      (peak_left),
    .peak_right     (peak_right),
    .slow_sq_left   (slow_sq_left),
    .slow_sq_right  (slow_sq_right),
    .slow_frames    (slow_frames),
    .fast_sq_left   (fast_sq_left),
    .fast_sq_right  (fast_sq_right),
    .fast_frames    (fast_frames),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .level_left     (level_left),
    .level_right    (level_right),
    .segments_left  (segments_left),
    .segments_right (segments_right)
  );

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stereo PPM level meter core. Ticks are sent
// through the valid/stall request channel, a bit-exact predictor of the dB
// targets and ballistics computes each expected result, and a monitor compares
// every accepted result field by field. Register settings are changed between
// phases while the meter is idle, and both sides insert random idle cycles.
// ----------------------------------------------------------------------------

module testbench;

  localparam int OFF_DB      = -15360;
  localparam int TOP_DB      = 1280;
  localparam int FLOOR_DB    = -30720;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [15:0] elapsed;
    logic        clear;
    logic        blk;
    logic [15:0] pk_l, pk_r;
    logic [42:0] ssq_l, ssq_r;
    logic [12:0] sn;
    logic [42:0] fsq_l, fsq_r;
    logic [12:0] fn;
  } tick_t;

  typedef struct {
    logic signed [14:0] lvl_l, lvl_r;
    logic [3:0]         seg_l, seg_r;
  } reading_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [15:0] elapsed_ms = 0;
  logic restart = 0, new_block = 0;
  logic [15:0] peak_left = 0, peak_right = 0;
  logic [42:0] slow_sq_left = 0, slow_sq_right = 0, fast_sq_left = 0, fast_sq_right = 0;
  logic [12:0] slow_frames = 0, fast_frames = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [14:0] level_left, level_right;
  logic [3:0] segments_left, segments_right;
  logic cfg_write = 0;
  logic [2:0] cfg_index = ppm_pkg::CFG_HOLD_TIME;
  logic [15:0] cfg_data = 0;

  audio_ppm_level_meter_core u_top (.*);

  // register copies
  int unsigned hold_cfg, release_cfg, max_tick_cfg, stale_cfg, cal_cfg, crest_cfg, boost_cfg;
  // meter state copies
  int          goal_db [2];
  int          shown_db [2];
  int unsigned hold_ms [2];
  int unsigned block_age;
  bit          have_block;

  reading_t expected_readings [$];
  int  tx_idle_pct = 0, rx_idle_pct = 0;
  bit  failed = 0;
  int  cycles = 0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stall
  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < rx_idle_pct);
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint log2_fix(longint unsigned x);
    int e;
    longint unsigned m, frac;
    e = 0;
    for (int i = 0; i < 64; i++) if (x[i]) e = i;
    m = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
    frac = 0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'((longint'(e) << 16) | frac);
  endfunction

  function automatic longint round_away(longint v, int s);
    longint unsigned u;
    u = (v < 0) ? -v : v;
    u = (u + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(u) : longint'(u);
  endfunction

  function automatic int clip(longint v, longint lo, longint hi);
    if (v < lo) return int'(lo);
    if (v > hi) return int'(hi);
    return int'(v);
  endfunction

  function automatic int peak_to_db(longint unsigned p);
    if (p == 0) return FLOOR_DB;
    return clip(round_away((log2_fix(p) - (longint'(15) << 16)) * 394566, 24), FLOOR_DB, 0);
  endfunction

  function automatic int power_to_db(longint unsigned sum, longint unsigned n);
    longint d;
    if (sum == 0 || n == 0) return FLOOR_DB;
    d = log2_fix(sum) - log2_fix(n) - (longint'(30) << 16);
    return clip(round_away(d * 394566, 25), FLOOR_DB, 0);
  endfunction

  function automatic int channel_target(longint unsigned pk, longint unsigned ssq,
                                        longint unsigned sn, longint unsigned fsq,
                                        longint unsigned fn);
    int slow, fast, pdb, act, boost;
    if (sn == 0) return OFF_DB;
    slow = power_to_db(ssq, sn);
    fast = power_to_db(fsq, fn);
    pdb  = peak_to_db(pk);
    act  = 0;
    if (ssq != 0 && fsq != 0 && fn != 0)
      act = clip(round_away(3 * longint'(fast - slow), 1), -512, 256);
    boost = clip(longint'(pdb) - slow - longint'(crest_cfg) * 256, 0,
                 longint'(boost_cfg) * 256);
    return clip(longint'(slow) + longint'(cal_cfg) * 256 + act + boost, OFF_DB, TOP_DB);
  endfunction

  function automatic void clear_meter_model();
    for (int c = 0; c < 2; c++) begin
      goal_db[c]  = OFF_DB;
      shown_db[c] = OFF_DB;
      hold_ms[c]  = 0;
    end
    block_age  = 0;
    have_block = 0;
  endfunction

  function automatic void move_needle(int c, int tgt, int unsigned dt);
    int d;
    if (tgt >= shown_db[c]) begin
      shown_db[c] = tgt;
      hold_ms[c]  = hold_cfg;
    end else if (hold_ms[c] > 0) begin
      hold_ms[c] = (hold_ms[c] > dt) ? hold_ms[c] - dt : 0;
    end else begin
      d = shown_db[c] - int'((release_cfg * dt * 256 + 500) / 1000);
      if (d < tgt) d = tgt;
      if (d < OFF_DB) d = OFF_DB;
      shown_db[c] = d;
    end
  endfunction

  function automatic logic [3:0] lit_segments(int db);
    logic [3:0] n;
    n = 0;
    for (int i = 0; i < 8; i++) if (db >= int'(ppm_pkg::SEG_THR[i])) n = 4'(i + 1);
    return n;
  endfunction

  function automatic reading_t meter_tick(tick_t t);
    int unsigned dt, sn, fn;
    bit quiet;
    reading_t r;
    dt = (t.elapsed > max_tick_cfg) ? max_tick_cfg : t.elapsed;
    if (t.clear) clear_meter_model();
    sn = (t.sn > 4096) ? 4096 : t.sn;
    fn = (t.fn > 4096) ? 4096 : t.fn;
    if (t.blk) begin
      have_block = 1;
      block_age  = 0;
      goal_db[0] = channel_target(t.pk_l, t.ssq_l, sn, t.fsq_l, fn);
      goal_db[1] = channel_target(t.pk_r, t.ssq_r, sn, t.fsq_r, fn);
    end else begin
      block_age = block_age + t.elapsed;
      if (block_age > 65535) block_age = 65535;
    end
    quiet = !have_block || block_age > stale_cfg;
    for (int c = 0; c < 2; c++) move_needle(c, quiet ? OFF_DB : goal_db[c], dt);
    r.lvl_l = shown_db[0][14:0];
    r.lvl_r = shown_db[1][14:0];
    r.seg_l = lit_segments(shown_db[0]);
    r.seg_r = lit_segments(shown_db[1]);
    return r;
  endfunction

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    reading_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected result level_left %0d level_right %0d", level_left, level_right);
        failed = 1;
      end else begin
        e = expected_readings.pop_front();
        if (level_left !== e.lvl_l) begin
          $error("level_left expected %0d actual %0d", e.lvl_l, level_left);
          failed = 1;
        end
        if (level_right !== e.lvl_r) begin
          $error("level_right expected %0d actual %0d", e.lvl_r, level_right);
          failed = 1;
        end
        if (segments_left !== e.seg_l) begin
          $error("segments_left expected %0d actual %0d", e.seg_l, segments_left);
          failed = 1;
        end
        if (segments_right !== e.seg_r) begin
          $error("segments_right expected %0d actual %0d", e.seg_r, segments_right);
          failed = 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_tick(tick_t t);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    elapsed_ms = t.elapsed; restart = t.clear; new_block = t.blk;
    peak_left = t.pk_l; peak_right = t.pk_r;
    slow_sq_left = t.ssq_l; slow_sq_right = t.ssq_r; slow_frames = t.sn;
    fast_sq_left = t.fsq_l; fast_sq_right = t.fsq_r; fast_frames = t.fn;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    expected_readings.push_back(meter_tick(t));
    @(negedge clk);
  endtask

  // hold off until every result is in, then let the core settle
  task automatic drain();
    in_valid = 0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_index = idx; cfg_data = val; cfg_write = 1;
    @(negedge clk);
    cfg_write = 0;
    case (idx)
      ppm_pkg::CFG_HOLD_TIME:   hold_cfg     = val & 16'h3FF;
      ppm_pkg::CFG_RELEASE:     release_cfg  = val & 16'hFF;
      ppm_pkg::CFG_MAX_TICK:    max_tick_cfg = val & 16'h3FF;
      ppm_pkg::CFG_STALE:       stale_cfg    = val;
      ppm_pkg::CFG_RMS_CAL:     cal_cfg      = val & 16'h3F;
      ppm_pkg::CFG_CREST_FLOOR: crest_cfg    = val & 16'h3F;
      ppm_pkg::CFG_BOOST_MAX:   boost_cfg    = val & 16'hF;
      default: ;
    endcase
  endtask

  task automatic set_regs(int h, int rl, int mt, int st, int cal, int cr, int bm);
    drain();
    write_reg(ppm_pkg::CFG_HOLD_TIME, 16'(h));
    write_reg(ppm_pkg::CFG_RELEASE, 16'(rl));
    write_reg(ppm_pkg::CFG_MAX_TICK, 16'(mt));
    write_reg(ppm_pkg::CFG_STALE, 16'(st));
    write_reg(ppm_pkg::CFG_RMS_CAL, 16'(cal));
    write_reg(ppm_pkg::CFG_CREST_FLOOR, 16'(cr));
    write_reg(ppm_pkg::CFG_BOOST_MAX, 16'(bm));
  endtask

  function automatic tick_t plain_tick(int el);
    tick_t t;
    t = '{default: '0};
    t.elapsed = 16'(el);
    return t;
  endfunction

  function automatic tick_t block_tick(int el, int pl, int pr, longint sl, longint sr,
                                       int sn, longint fl, longint fr, int fn);
    tick_t t;
    t = plain_tick(el);
    t.blk = 1; t.pk_l = 16'(pl); t.pk_r = 16'(pr); t.ssq_l = 43'(sl); t.ssq_r = 43'(sr);
    t.sn = 13'(sn);
    t.fsq_l = 43'(fl); t.fsq_r = 43'(fr); t.fn = 13'(fn);
    return t;
  endfunction

  // sum of squares of varying magnitude
  function automatic logic [42:0] rand_power(int n);
    longint unsigned r;
    int a;
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 43'({$urandom, $urandom});
      2: return 43'h400_0000_0000;
      default: begin
        a = $urandom_range(0, 32768) >> $urandom_range(0, 15);
        r = longint'(a) * a * n;
        return r[42:0];
      end
    endcase
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    int n;
    t = plain_tick($urandom_range(0, 19) == 0 ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 150));
    t.clear = ($urandom_range(0, 29) == 0);
    t.blk   = ($urandom_range(0, 99) < 65);
    if (t.blk) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4096);
      t.sn = 13'(n);
      t.fn = 13'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : (n + 3) / 4);
      t.pk_l = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 32768) >> $urandom_range(0, 15));
      t.pk_r = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 32768) >> $urandom_range(0, 15));
      t.ssq_l = rand_power(n); t.ssq_r = rand_power(n);
      t.fsq_l = rand_power(t.fn); t.fsq_r = rand_power(t.fn);
    end else if ($urandom_range(0, 3) == 0) begin
      // ignored payload on a plain tick
      t.pk_l = 16'($urandom); t.ssq_r = 43'({$urandom, $urandom}); t.sn = 13'($urandom);
    end
    return t;
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    longint fs;
    fs = 64'h7FF_FFFF_FFFF;
    send_tick(plain_tick(10));                                    // silent before any block
    send_tick(block_tick(20, 32768, 16384, 1 << 40, 1 << 36, 4096, 1 << 40, 1 << 30, 1024));
    send_tick(plain_tick(50));                                    // hold
    send_tick(plain_tick(100));
    send_tick(plain_tick(400));                                   // stale block
    send_tick(block_tick(5, 0, 0, 0, 0, 4096, 0, 0, 0));          // zero sums and peaks
    send_tick(block_tick(5, 1000, 1000, 1 << 30, 1 << 30, 0, 1, 1, 1)); // no slow data
    send_tick(block_tick(5, 65535, 40000, fs, fs, 1, fs, fs, 1)); // over full scale
    send_tick(block_tick(5, 32768, 32768, 43'h400_0000_0000, 43'h400_0000_0000, 4096,
                         43'h400_0000_0000, 1, 4096));
    send_tick(block_tick(5, 12000, 30000, 1 << 35, 1 << 38, 8191, 1 << 36, 1 << 33, 8191));
    send_tick(block_tick(5, 9000, 9000, 1 << 33, 1 << 33, 4096, 1 << 33, 1 << 33, 0));
    send_tick(block_tick(5, 20000, 1, 1 << 20, 1 << 41, 2048, 1 << 42, 1 << 15, 512));
    send_tick(plain_tick(0));
    send_tick(plain_tick(65535));                                 // age saturates
    send_tick(plain_tick(65535));
    begin
      tick_t t;
      t = block_tick(30, 30000, 30000, 1 << 40, 1 << 40, 4096, 1 << 40, 1 << 40, 1024);
      t.clear = 1;                                                // restart with a block
      send_tick(t);
      t = plain_tick(30);
      t.clear = 1;                                                // restart alone
      send_tick(t);
    end
    send_tick(block_tick(16'hFFFF, 32768, 100, 1 << 39, 1 << 20, 4096, 1 << 41, 1 << 19, 1024));
    send_tick(plain_tick(1));
  endtask

  task automatic test_random(int count, int tx, int rx);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    for (int i = 0; i < count; i++) begin
      send_tick(rand_tick());
      if (i == count / 2) drain();
    end
  endtask

  task automatic test_register_extremes();
    set_regs(0, 255, 1, 1, 0, 0, 15);
    test_random(140, 8, 56);
    set_regs(1000, 0, 1000, 65535, 63, 63, 0);
    test_random(140, 56, 8);
    set_regs(16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_random(80, 8, 56);
    set_regs(300, 40, 250, 500, 20, 6, 8);
    test_random(260, 0, 0);
  endtask

  initial begin
    hold_cfg = 120; release_cfg = 12; max_tick_cfg = 100; stale_cfg = 300;
    cal_cfg = 14; crest_cfg = 10; boost_cfg = 4;
    clear_meter_model();
    repeat (7) @(negedge clk);
    rst = 0;
    test_directed();
    test_register_extremes();
    drain();
    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
